>>> design/assert_macros.svh
// Assertion helpers for the design files; the stream top includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside of reset.
`define CTS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define CTS_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/cts_pkg.sv
`timescale 1ns / 1ps

package cts_pkg;

  // Default sizes.
  localparam int DEF_LOOKAHEAD = 7;
  localparam int DEF_CHAR_BITS = 16;

  // Comment mode bits.
  localparam logic [1:0] CM_BLOCK = 2'b01;
  localparam logic [1:0] CM_LINE  = 2'b10;

  // Character codes.
  localparam logic [7:0] CH_SLASH = "/";
  localparam logic [7:0] CH_STAR  = "*";
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SP    = " ";
  localparam logic [7:0] CH_0     = "0";
  localparam logic [7:0] CH_9     = "9";
  localparam logic [7:0] CH_HASH  = "#";
  localparam logic [7:0] CH_DOT   = ".";

  // Operator tables.
  localparam logic [7:0] OPS4 [4] = '{">", ">", ">", "="};
  localparam logic [7:0] OPS3 [3][3] = '{
    '{">", ">", ">"}, '{">", ">", "="}, '{"<", "<", "="}
  };
  localparam logic [7:0] OPS2 [15][2] = '{
    '{"#", "#"}, '{"+", "+"}, '{"-", "-"}, '{"|", "|"}, '{"&", "&"},
    '{"+", "="}, '{"-", "="}, '{"*", "="}, '{"/", "="}, '{"&", "="},
    '{"|", "="}, '{"=", "="}, '{"~", "="}, '{"<", "<"}, '{">", ">"}
  };

  // Single punctuation characters.
  localparam logic [7:0] PUNCT [19] = '{
    ":", ";", "(", "[", "]", ")", "}", ",", "{", "<",
    ">", "+", "-", "*", "/", "^", "%", "!", "="
  };

  // Directive that keeps a hash inside a word.
  localparam logic [7:0] DEFINE_SEQ [7] = '{"#", "d", "e", "f", "i", "n", "e"};

  // Tokenizer control state.
  typedef struct packed {
    logic [1:0] opr;
    logic [1:0] cm;
    logic       word_open;
  } cts_ctl_t;

  // Emitted character flags.
  typedef struct packed {
    logic valid;
    logic start;
  } cts_emit_t;

endpackage

>>> design/cts_in_if.sv
`timescale 1ns / 1ps

interface cts_in_if import cts_pkg::*; #(
  parameter int CHAR_BITS = DEF_CHAR_BITS
) ();
  logic                 valid;
  logic                 ready;
  logic [CHAR_BITS-1:0] ch;
  logic                 end_of_text;

  modport source (output valid, ch, end_of_text, input ready);
  modport sink (input valid, ch, end_of_text, output ready);
endinterface

interface cts_out_if import cts_pkg::*; #(
  parameter int CHAR_BITS = DEF_CHAR_BITS
) ();
  logic                 valid;
  logic                 ready;
  logic [CHAR_BITS-1:0] out_char;
  logic                 has_char;
  logic                 token_start;
  logic                 text_done;
  logic                 last;

  modport source (output valid, out_char, has_char, token_start, text_done, last,
                  input ready);
  modport sink (input valid, out_char, has_char, token_start, text_done, last,
                output ready);
endinterface

>>> design/code_tokenizer_stream_top.sv
// Output: the emitted character is registered and leaves in the cycle after the beat that fills the window.
// Throughput: one input beat per cycle while the output side takes beats and no end-of-text flush is in progress.
// End of text: input is held off while the window drains one or two characters per
// step whenever the output slot is free, then an end marker follows.
// Reset: synchronous, active low; clears the window state and output valid.
`timescale 1ns / 1ps

module code_tokenizer_stream_top import cts_pkg::*; #(
  parameter int LOOKAHEAD = DEF_LOOKAHEAD
) (
  input  logic      clk,
  input  logic      rst_n,
  cts_in_if.sink    in_bus,
  cts_out_if.source out_bus
);

`include "assert_macros.svh"

  // Character width is the package default, which is also the channel interfaces' default.
  localparam int CHAR_BITS = DEF_CHAR_BITS;
  localparam int FW = $clog2(LOOKAHEAD + 1);

  logic [CHAR_BITS-1:0] win_r [LOOKAHEAD];
  logic [CHAR_BITS-1:0] win_push [LOOKAHEAD];
  logic [CHAR_BITS-1:0] core_win [LOOKAHEAD];
  logic [CHAR_BITS-1:0] core_win_nxt [LOOKAHEAD];
  logic [FW-1:0]        fill_r;
  logic [FW-1:0]        core_avail;
  logic [FW-1:0]        core_fill_nxt;
  cts_ctl_t             ctl_r;
  cts_ctl_t             core_ctl_nxt;
  logic [CHAR_BITS-1:0] prev_r;
  logic [CHAR_BITS-1:0] core_prev_nxt;
  cts_emit_t            core_emit;
  logic [CHAR_BITS-1:0] core_char;
  logic                 flush_r;
  logic                 slot_free;
  logic                 accept;
  logic                 full_step;
  logic                 flush_step;

  logic                 out_valid_r;
  logic [CHAR_BITS-1:0] out_char_r;
  logic                 out_has_char_r;
  logic                 out_token_start_r;
  logic                 out_text_done_r;
  logic                 out_last_r;

  // Handshake.
  assign slot_free    = !out_valid_r || out_bus.ready;
  assign in_bus.ready = !flush_r && slot_free;
  assign accept       = in_bus.valid && in_bus.ready;
  assign full_step    = accept && !in_bus.end_of_text && fill_r == FW'(LOOKAHEAD - 1);
  assign flush_step   = flush_r && slot_free;

  // Window with the incoming character appended.
  always_comb begin
    for (int k = 0; k < LOOKAHEAD; k++) begin
      win_push[k] = (FW'(k) == fill_r) ? in_bus.ch : win_r[k];
    end
  end

  assign core_win   = flush_r ? win_r : win_push;
  assign core_avail = flush_r ? fill_r : FW'(LOOKAHEAD);

  cts_core #(
    .LOOKAHEAD(LOOKAHEAD),
    .CHAR_BITS(CHAR_BITS)
  ) u_core (
    .win      (core_win),
    .avail    (core_avail),
    .ctl      (ctl_r),
    .prev     (prev_r),
    .win_nxt  (core_win_nxt),
    .fill_nxt (core_fill_nxt),
    .ctl_nxt  (core_ctl_nxt),
    .prev_nxt (core_prev_nxt),
    .emit     (core_emit),
    .emit_char(core_char)
  );

  // Window payload.
  always_ff @(posedge clk) begin
    if (full_step || (flush_step && fill_r != '0)) begin
      win_r <= core_win_nxt;
    end else if (accept) begin
      win_r <= win_push;
    end
  end

  // Tokenizer control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r  <= '0;
      ctl_r   <= '0;
      prev_r  <= '0;
      flush_r <= 1'b0;
    end else if (full_step || (flush_step && fill_r != '0)) begin
      fill_r <= core_fill_nxt;
      ctl_r  <= core_ctl_nxt;
      prev_r <= core_prev_nxt;
    end else if (flush_step) begin
      fill_r  <= '0;
      ctl_r   <= '0;
      prev_r  <= '0;
      flush_r <= 1'b0;
    end else if (accept) begin
      fill_r  <= fill_r + FW'(1);
      flush_r <= in_bus.end_of_text;
    end
  end

  // Output register valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((full_step && core_emit.valid)
                 || (flush_step && (fill_r == '0 || core_emit.valid))) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (flush_step && fill_r == '0) begin
      out_char_r        <= '0;
      out_has_char_r    <= 1'b0;
      out_token_start_r <= 1'b0;
      out_text_done_r   <= 1'b1;
      out_last_r        <= 1'b1;
    end else if ((full_step || flush_step) && core_emit.valid) begin
      out_char_r        <= core_char;
      out_has_char_r    <= 1'b1;
      out_token_start_r <= core_emit.start;
      out_text_done_r   <= 1'b0;
      out_last_r        <= !flush_r;
    end
  end

  assign out_bus.valid       = out_valid_r;
  assign out_bus.out_char    = out_char_r;
  assign out_bus.has_char    = out_has_char_r;
  assign out_bus.token_start = out_token_start_r;
  assign out_bus.text_done   = out_text_done_r;
  assign out_bus.last        = out_last_r;

  // Checks.
  `CTS_ASSERT(a_fill_bound, fill_r <= FW'(LOOKAHEAD), "window fill out of range")
  `CTS_ASSERT(a_flush_blocks, flush_r |-> !in_bus.ready, "input taken during flush")
  `CTS_ASSERT(a_end_marker, out_valid_r && out_text_done_r |-> !out_has_char_r && out_last_r,
              "malformed end marker")
  `CTS_ASSERT(a_op_no_comment, ctl_r.opr != 2'd0 |-> ctl_r.cm == 2'b00,
              "operator body inside comment")
  `CTS_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_valid_r && !flush_r,
                     "state not cleared by reset")

endmodule

>>> design/cts_core.sv
`timescale 1ns / 1ps

module cts_core import cts_pkg::*; #(
  parameter int LOOKAHEAD = DEF_LOOKAHEAD,
  parameter int CHAR_BITS = DEF_CHAR_BITS,
  localparam int FW = $clog2(LOOKAHEAD + 1)
) (
  input  logic [CHAR_BITS-1:0] win [LOOKAHEAD],
  input  logic [FW-1:0]        avail,
  input  cts_ctl_t             ctl,
  input  logic [CHAR_BITS-1:0] prev,
  output logic [CHAR_BITS-1:0] win_nxt [LOOKAHEAD],
  output logic [FW-1:0]        fill_nxt,
  output cts_ctl_t             ctl_nxt,
  output logic [CHAR_BITS-1:0] prev_nxt,
  output cts_emit_t            emit,
  output logic [CHAR_BITS-1:0] emit_char
);

  localparam int PAD = 10;

  logic [CHAR_BITS-1:0] wx [PAD];
  logic [CHAR_BITS-1:0] c;
  logic [2:0]           len;
  logic                 def_hit;
  logic                 single;
  logic                 skip;
  logic                 drop2;

  // Window padded with zeros past its end.
  for (genvar k = 0; k < PAD; k++) begin : g_pad
    if (k < LOOKAHEAD) begin : g_in
      assign wx[k] = win[k];
    end else begin : g_zero
      assign wx[k] = '0;
    end
  end

  assign c = wx[0];

  // True when window slot k is valid and holds code cc.
  function automatic logic at(input int k, input logic [7:0] cc);
    return (k < int'(avail)) && (wx[k] == CHAR_BITS'(cc));
  endfunction

  // Operator length and the directive check.
  always_comb begin
    len = 3'd0;
    for (int i = 0; i < 15; i++) begin
      if (at(0, OPS2[i][0]) && at(1, OPS2[i][1])) len = 3'd2;
    end
    for (int i = 0; i < 3; i++) begin
      if (at(0, OPS3[i][0]) && at(1, OPS3[i][1]) && at(2, OPS3[i][2])) len = 3'd3;
    end
    if (at(0, OPS4[0]) && at(1, OPS4[1]) && at(2, OPS4[2]) && at(3, OPS4[3])) begin
      len = 3'd4;
    end
    def_hit = 1'b1;
    for (int k = 0; k < 7; k++) begin
      if (!at(k, DEFINE_SEQ[k])) def_hit = 1'b0;
    end
  end

  // Single-character token test.
  always_comb begin
    single = 1'b0;
    for (int i = 0; i < 19; i++) begin
      if (c == CHAR_BITS'(PUNCT[i])) single = 1'b1;
    end
    if (c == CHAR_BITS'(CH_DOT)) begin
      single = (prev < CHAR_BITS'(CH_0)) || (prev > CHAR_BITS'(CH_9));
    end
    if (c == CHAR_BITS'(CH_HASH)) begin
      single = !def_hit;
    end
  end

  // Decide the oldest window character.
  always_comb begin
    ctl_nxt   = ctl;
    emit      = '0;
    emit_char = c;
    skip      = 1'b0;
    drop2     = 1'b0;
    if (ctl.opr != 2'd0) begin
      emit.valid  = 1'b1;
      ctl_nxt.opr = ctl.opr - 2'd1;
    end else begin
      if (c == CHAR_BITS'(CH_SLASH) && at(1, CH_STAR)) begin
        ctl_nxt.cm = ctl.cm | CM_BLOCK;
      end else if (c == CHAR_BITS'(CH_SLASH) && at(1, CH_SLASH)) begin
        ctl_nxt.cm = ctl.cm | CM_LINE;
      end else if ((ctl.cm & CM_BLOCK) != 2'b00 && c == CHAR_BITS'(CH_STAR)
                   && at(1, CH_SLASH)) begin
        ctl_nxt.cm = ctl.cm & ~CM_BLOCK;
        drop2      = 1'b1;
        skip       = 1'b1;
      end else if ((ctl.cm & CM_LINE) != 2'b00 && c == CHAR_BITS'(CH_NL)) begin
        ctl_nxt.cm = ctl.cm & ~CM_LINE;
        skip       = 1'b1;
      end
      if (!skip && ctl_nxt.cm == 2'b00) begin
        if (len != 3'd0) begin
          ctl_nxt.word_open = 1'b0;
          emit.valid        = 1'b1;
          emit.start        = 1'b1;
          ctl_nxt.opr       = 2'(len - 3'd1);
        end else if (single) begin
          ctl_nxt.word_open = 1'b0;
          emit.valid        = 1'b1;
          emit.start        = 1'b1;
        end else if (c == CHAR_BITS'(CH_SP) || c == CHAR_BITS'(CH_NL)) begin
          ctl_nxt.word_open = 1'b0;
        end else if (c > CHAR_BITS'(CH_SP)) begin
          emit.valid        = 1'b1;
          emit.start        = !ctl.word_open;
          ctl_nxt.word_open = 1'b1;
        end
      end
    end
  end

  // Shift out one or two characters.
  always_comb begin
    for (int k = 0; k < LOOKAHEAD; k++) begin
      win_nxt[k] = drop2 ? wx[k + 2] : wx[k + 1];
    end
    prev_nxt = drop2 ? wx[1] : wx[0];
    fill_nxt = drop2 ? avail - FW'(2) : avail - FW'(1);
  end

endmodule
